@@ rtl/dnm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the dense neuron MAC and activation block.
// Used by dnm_front, dnm_back, dense_neuron_mac_activation_top, dnm_checker and tb_top; no dependencies.
package dnm_pkg;

    localparam int DATA_W      = 16;
    localparam int FRAC_BITS   = 12;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SIG_ARG_W   = DATA_W + 1;
    localparam int SIG_W       = FRAC_BITS + 3;
    localparam int SCALE_W     = DATA_W + SIG_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int S_TDATA_W   = 3 * DATA_W;
    localparam int M_TDATA_W   = 2 * DATA_W;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Leaky ReLU slope of about 0.01, as a Q0.16 factor.
    localparam int LEAKY_SLOPE = 655;
    localparam int LEAKY_SHIFT = 16;

    typedef logic [2:0] act_mode_t;
    localparam act_mode_t MODE_RELU    = 3'd0;
    localparam act_mode_t MODE_SIGMOID = 3'd1;
    localparam act_mode_t MODE_TANH    = 3'd2;
    localparam act_mode_t MODE_LEAKY   = 3'd3;
    localparam act_mode_t MODE_SWISH   = 3'd4;
    localparam act_mode_t MODE_LINEAR  = 3'd5;

    localparam logic REG_ACT_MODE = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] in_value;
        logic signed [DATA_W-1:0] weight_value;
        logic signed [DATA_W-1:0] bias_value;
        logic                     first_element;
        logic                     last_element;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ACC,
        BK_PRE,
        BK_SIG,
        BK_SCALE,
        BK_FIN
    } back_state_t;

endpackage

@@ rtl/dense_neuron_mac_activation_top.sv @@
`timescale 1ns / 1ps
// Top level of the dense neuron MAC and activation block: config register and wiring.
// Depends on dnm_pkg, dnm_front and dnm_back.
//
//  Channel   Direction  Handshake          Contents
//  s_        in         s_tvalid/s_tready  in, weight, bias; first in tuser, last in tlast
//  m_        out        m_tvalid/m_tready  activated, pre-activation; saturated in tuser
//  APB       in/out     psel/penable       register 0: activation_mode (reset 5, linear)
//
// A non-last element passes through IDLE and ACC (multiply, accumulate); a last element
// goes on through PRE, SIG, SCALE and FIN (bias rounding, sigmoid, scale multiply, result).
// A four-entry queue decouples input acceptance from the MAC datapath.
// Reset is synchronous on aresetn low and clears the queue, accumulator and result valid.
// A stalled m_tready holds the result register; the queue keeps accepting until it fills.
module dense_neuron_mac_activation_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata fields from bit 0 up: in_value, weight_value, bias_value
    input  logic [dnm_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0 up: first_element
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields from bit 0 up: activated_value, pre_activation
    output logic [dnm_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser fields from bit 0 up: saturated
    output logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dnm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dnm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dnm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import dnm_pkg::*;

    act_mode_t   act_mode_reg;
    queue_head_t head;
    logic        pop;
    logic        reg_write;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_ACT_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_mode_reg <= MODE_LINEAR;
        end else if (reg_write) begin
            act_mode_reg <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1] == REG_ACT_MODE)
                  ? APB_DATA_W'(act_mode_reg) : '0;

    dnm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .head     (head),
        .pop      (pop)
    );

    dnm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .act_mode (act_mode_reg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/dnm_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts stream transactions and queues them for the back end.
// Depends on dnm_pkg.
module dnm_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0 up: in_value, weight_value, bias_value
    input  logic [dnm_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser fields from bit 0 up: first_element
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output dnm_pkg::queue_head_t            head,
    input  logic                            pop
);
    import dnm_pkg::*;

    item_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push;
    item_t             in_item;

    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;

    always_comb begin
        in_item.in_value      = s_tdata[DATA_W-1:0];
        in_item.weight_value  = s_tdata[2*DATA_W-1:DATA_W];
        in_item.bias_value    = s_tdata[3*DATA_W-1:2*DATA_W];
        in_item.first_element = s_tuser;
        in_item.last_element  = s_tlast;
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not raise the count");

endmodule

@@ rtl/dnm_back.sv @@
`timescale 1ns / 1ps
// Back end: multiply-accumulate, bias, rounding, activation and result register.
// Depends on dnm_pkg.
module dnm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dnm_pkg::act_mode_t              act_mode,
    input  dnm_pkg::queue_head_t            head,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: activated_value, pre_activation
    output logic [dnm_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser fields from bit 0 up: saturated
    output logic                            m_tuser
);
    import dnm_pkg::*;

    localparam int SUM_W  = ACC_W + 1;
    localparam int PRE_W  = SUM_W - FRAC_BITS;
    localparam int WIDE_W = SCALE_W + 1;
    localparam int ACT_W  = WIDE_W - FRAC_BITS;

    // Piecewise-linear sigmoid; thresholds at 5, 2.375 and 1.
    function automatic logic signed [SIG_W-1:0] sigmoid_pl(
        input logic signed [SIG_ARG_W-1:0] x
    );
        logic [SIG_ARG_W-1:0] a;
        logic [SIG_ARG_W:0]   t;
        logic [SIG_W-1:0]     y;
        a = x[SIG_ARG_W-1] ? SIG_ARG_W'(-x) : SIG_ARG_W'(x);
        if (a >= SIG_ARG_W'(5 << FRAC_BITS)) begin
            y = SIG_W'(1 << FRAC_BITS);
        end else if (a >= SIG_ARG_W'((19 << FRAC_BITS) / 8)) begin
            t = {1'b0, a} + (SIG_ARG_W+1)'(27 << FRAC_BITS);
            y = SIG_W'(t >> 5);
        end else if (a >= SIG_ARG_W'(1 << FRAC_BITS)) begin
            t = {1'b0, a} + (SIG_ARG_W+1)'(5 << FRAC_BITS);
            y = SIG_W'(t >> 3);
        end else begin
            t = {1'b0, a} + (SIG_ARG_W+1)'(2 << FRAC_BITS);
            y = SIG_W'(t >> 2);
        end
        if (x[SIG_ARG_W-1]) begin
            y = SIG_W'(1 << FRAC_BITS) - y;
        end
        return $signed(y);
    endfunction

    back_state_t state_reg, state_next;

    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DATA_W-1:0]  bias_reg;
    logic                      first_reg, last_reg;
    logic signed [DATA_W-1:0]  pre_reg;
    logic                      sat_reg;
    logic signed [SIG_W-1:0]   sig_reg;
    logic signed [SCALE_W-1:0] scale_reg;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  out_act_reg, out_pre_reg;
    logic                      out_sat_reg;

    logic                      load_out;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [SUM_W-1:0]   bias_sum;
    logic signed [PRE_W-1:0]   pre_wide;
    logic signed [DATA_W-1:0]  pre_clip;
    logic                      pre_sat;
    logic signed [SIG_ARG_W-1:0] sig_arg;
    logic signed [SIG_W-1:0]   scale_factor;
    logic signed [WIDE_W-1:0]  round_sum;
    logic signed [ACT_W-1:0]   act_wide;
    logic signed [DATA_W-1:0]  act_clip;
    logic signed [SIG_W+1:0]   tanh_val;
    logic signed [WIDE_W-1:0]  leaky_sum;

    // Accumulate with saturation at the accumulator limits.
    always_comb begin
        acc_base = first_reg ? '0 : acc_reg;
        acc_sum  = SUM_W'(acc_base) + SUM_W'(prod_reg);
        if (acc_sum[SUM_W-1] != acc_sum[SUM_W-2]) begin
            acc_next = acc_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // Bias at accumulator scale, round half up, then clip to the data width.
    always_comb begin
        bias_sum = SUM_W'(acc_reg) + (SUM_W'(bias_reg) <<< FRAC_BITS)
                 + SUM_W'(1 << (FRAC_BITS - 1));
        pre_wide = bias_sum[SUM_W-1:FRAC_BITS];
        pre_sat  = (pre_wide[PRE_W-1:DATA_W-1] != {(PRE_W-DATA_W+1){1'b0}})
                && (pre_wide[PRE_W-1:DATA_W-1] != {(PRE_W-DATA_W+1){1'b1}});
        if (pre_sat) begin
            pre_clip = pre_wide[PRE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            pre_clip = pre_wide[DATA_W-1:0];
        end
    end

    always_comb begin
        sig_arg      = (act_mode == MODE_TANH) ? (SIG_ARG_W'(pre_reg) <<< 1)
                                               : SIG_ARG_W'(pre_reg);
        scale_factor = (act_mode == MODE_LEAKY) ? SIG_W'(LEAKY_SLOPE) : sig_reg;
    end

    always_comb begin
        round_sum = WIDE_W'(scale_reg) + WIDE_W'(1 << (FRAC_BITS - 1));
        leaky_sum = WIDE_W'(scale_reg) + WIDE_W'(1 << (LEAKY_SHIFT - 1));
        tanh_val  = ((SIG_W+2)'(sig_reg) <<< 1) - (SIG_W+2)'(1 << FRAC_BITS);
        unique case (act_mode)
            MODE_RELU: begin
                act_wide = (pre_reg > 0) ? ACT_W'(pre_reg) : '0;
            end
            MODE_SIGMOID: begin
                act_wide = ACT_W'(sig_reg);
            end
            MODE_TANH: begin
                act_wide = ACT_W'(tanh_val);
            end
            MODE_LEAKY: begin
                act_wide = (pre_reg > 0) ? ACT_W'(pre_reg)
                                         : ACT_W'($signed(leaky_sum[WIDE_W-1:LEAKY_SHIFT]));
            end
            MODE_SWISH: begin
                act_wide = round_sum[WIDE_W-1:FRAC_BITS];
            end
            default: begin
                act_wide = ACT_W'(pre_reg);
            end
        endcase
        if ((act_wide[ACT_W-1:DATA_W-1] != {(ACT_W-DATA_W+1){1'b0}})
                && (act_wide[ACT_W-1:DATA_W-1] != {(ACT_W-DATA_W+1){1'b1}})) begin
            act_clip = act_wide[ACT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            act_clip = act_wide[DATA_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (head.valid) begin
                    pop        = 1'b1;
                    state_next = BK_ACC;
                end
            end
            BK_ACC: begin
                state_next = last_reg ? BK_PRE : BK_IDLE;
            end
            BK_PRE: begin
                state_next = BK_SIG;
            end
            BK_SIG: begin
                state_next = BK_SCALE;
            end
            BK_SCALE: begin
                state_next = BK_FIN;
            end
            BK_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == BK_ACC) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            prod_reg  <= PROD_W'(head.item.in_value) * PROD_W'(head.item.weight_value);
            bias_reg  <= head.item.bias_value;
            first_reg <= head.item.first_element;
            last_reg  <= head.item.last_element;
        end
        if (state_reg == BK_PRE) begin
            pre_reg <= pre_clip;
            sat_reg <= pre_sat;
        end
        if (state_reg == BK_SIG) begin
            sig_reg <= sigmoid_pl(sig_arg);
        end
        if (state_reg == BK_SCALE) begin
            scale_reg <= SCALE_W'(pre_reg) * SCALE_W'(scale_factor);
        end
        if (load_out) begin
            out_act_reg <= act_clip;
            out_pre_reg <= pre_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pre_reg, out_act_reg};
    assign m_tuser  = out_sat_reg;

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("result load did not raise m_tvalid");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == BK_IDLE))
        else $error("queue popped outside the idle state");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SIG && sat_reg)
            |-> (pre_reg == {1'b0, {(DATA_W-1){1'b1}}}
                 || pre_reg == {1'b1, {(DATA_W-1){1'b0}}}))
        else $error("saturation flag set on an unclipped value");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !load_out)
        else $error("pending result overwritten");

endmodule

@@ dv/dnm_checker.sv @@
`timescale 1ns / 1ps
// Checker for dense_neuron_mac_activation_top: it watches the input, result and APB ports,
// keeps its own copy of the accumulator and activation mode, and compares every result.
// Depends on dnm_pkg only.
module dnm_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    // s_tdata fields from bit 0 up: in_value, weight_value, bias_value
    input  logic [dnm_pkg::S_TDATA_W-1:0]        s_tdata,
    // s_tuser fields from bit 0 up: first_element
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata fields from bit 0 up: activated_value, pre_activation
    input  logic [dnm_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser fields from bit 0 up: saturated
    input  logic                                 m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dnm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [dnm_pkg::APB_DATA_W-1:0]       pwdata,
    input  logic [dnm_pkg::APB_DATA_W-1:0]       prdata,
    input  logic                                 pready,
    output int unsigned                          fail_count,
    output int unsigned                          outstanding,
    output int unsigned                          results_seen
);
    import dnm_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] activated;
        logic signed [DATA_W-1:0] pre_act;
        logic                     clipped;
    } neuron_result_t;

    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam logic [APB_ADDR_W-1:0] ACT_MODE_ADDR = APB_ADDR_W'(4 * int'(REG_ACT_MODE));
    localparam int unsigned PRINT_LIMIT = 50;

    neuron_result_t expected_results[$];
    longint         acc_q24;
    act_mode_t      mode_copy;

    initial begin
        fail_count   = 0;
        outstanding  = 0;
        results_seen = 0;
        acc_q24      = 0;
        mode_copy    = MODE_LINEAR;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic longint saturate(input longint v, input int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Round half up: add half an LSB, then an arithmetic shift floors.
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Piecewise-linear sigmoid in Q.FRAC_BITS, mirrored for negative arguments.
    function automatic longint sigmoid_pwl(input longint x);
        longint a, y;
        a = (x < 0) ? -x : x;
        if (a >= 5 * ONE)
            y = ONE;
        else if (a * 8 >= 19 * ONE)
            y = (a + 27 * ONE) >>> 5;
        else if (a >= ONE)
            y = (a + 5 * ONE) >>> 3;
        else
            y = (a + 2 * ONE) >>> 2;
        return (x < 0) ? ONE - y : y;
    endfunction

    // Accumulates one element; returns 1 with the expected result when the element ends a
    // dot product.
    function automatic bit accumulate_element(input item_t it, output neuron_result_t res);
        longint pre_wide, pre, act;
        res = '0;
        if (it.first_element)
            acc_q24 = 0;
        acc_q24 = saturate(acc_q24 + longint'($signed(it.in_value))
                           * longint'($signed(it.weight_value)), ACC_W);
        if (!it.last_element)
            return 1'b0;
        pre_wide = round_half_up(acc_q24 + longint'($signed(it.bias_value)) * ONE, FRAC_BITS);
        pre = saturate(pre_wide, DATA_W);
        case (mode_copy)
            MODE_RELU:    act = (pre > 0) ? pre : 0;
            MODE_SIGMOID: act = sigmoid_pwl(pre);
            MODE_TANH:    act = 2 * sigmoid_pwl(2 * pre) - ONE;
            MODE_LEAKY:   act = (pre > 0) ? pre : round_half_up(pre * LEAKY_SLOPE, LEAKY_SHIFT);
            MODE_SWISH:   act = round_half_up(pre * sigmoid_pwl(pre), FRAC_BITS);
            default:      act = pre;
        endcase
        res.activated = DATA_W'(saturate(act, DATA_W));
        res.pre_act   = DATA_W'(pre);
        res.clipped   = (pre != pre_wide);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : monitor
        neuron_result_t want, got;
        item_t          elem;
        if (!aresetn) begin
            expected_results.delete();
            acc_q24   = 0;
            mode_copy = MODE_LINEAR;
        end else begin
            // Results are compared before this edge's input is predicted, since an input
            // transaction can never produce a result in the same cycle.
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.activated = m_tdata[0 +: DATA_W];
                got.pre_act   = m_tdata[DATA_W +: DATA_W];
                got.clipped   = m_tuser;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with nothing expected",
                                              got.activated, got.pre_act, got.clipped));
                end else begin
                    want = expected_results.pop_front();
                    if (got.activated !== want.activated)
                        report_mismatch($sformatf("activated_value %0d, expected %0d (mode %0d)",
                                                  got.activated, want.activated, mode_copy));
                    if (got.pre_act !== want.pre_act)
                        report_mismatch($sformatf("pre_activation %0d, expected %0d",
                                                  got.pre_act, want.pre_act));
                    if (got.clipped !== want.clipped)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  got.clipped, want.clipped));
                end
            end
            if (s_tvalid && s_tready) begin
                elem.in_value      = s_tdata[0 +: DATA_W];
                elem.weight_value  = s_tdata[DATA_W +: DATA_W];
                elem.bias_value    = s_tdata[2 * DATA_W +: DATA_W];
                elem.first_element = s_tuser;
                elem.last_element  = s_tlast;
                if (accumulate_element(elem, want))
                    expected_results.push_back(want);
            end
            if (psel && penable && pready && paddr == ACT_MODE_ADDR) begin
                if (pwrite)
                    mode_copy = act_mode_t'(pwdata[2:0]);
                else if (prdata !== APB_DATA_W'(mode_copy))
                    report_mismatch($sformatf("activation_mode read %0h, expected %0h",
                                              prdata, mode_copy));
            end
        end
        outstanding = expected_results.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for dense_neuron_mac_activation_top: clock, reset, stimulus and verdict.
// Depends on dnm_pkg, the block's RTL and dnm_checker, which does all result checking.
module tb_top;
    import dnm_pkg::*;

    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 47;
    localparam int OVERFLOW_UP     = 515;
    localparam int OVERFLOW_DOWN   = 512;
    localparam act_mode_t MODE_TOP_CODE = '1;
    localparam logic [APB_ADDR_W-1:0] ACT_MODE_ADDR = APB_ADDR_W'(4 * int'(REG_ACT_MODE));

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned results_seen;
    int unsigned items_sent = 0;
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;

    dense_neuron_mac_activation_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dnm_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Ends the run if no transaction of any kind completes for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results still due",
                 WATCHDOG_LIMIT, outstanding);
        $display("** dense_neuron_mac_activation_top: FAILED **");
        $finish;
    end

    function automatic item_t make_item(input logic signed [DATA_W-1:0] x,
                                        input logic signed [DATA_W-1:0] w,
                                        input logic signed [DATA_W-1:0] b,
                                        input logic first, input logic last);
        item_t it;
        it.in_value      = x;
        it.weight_value  = w;
        it.bias_value    = b;
        it.first_element = first;
        it.last_element  = last;
        return it;
    endfunction

    // Values within +/-2.0 (42%), over the full range (50%) and a few corners (8%).
    function automatic logic signed [DATA_W-1:0] pick_operand();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) begin
            case ($urandom_range(5))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return 16'sh0000;
                3:       return -16'sd1;
                4:       return 16'sd4096;
                default: return -16'sd4096;
            endcase
        end
        if (r < 50)
            return DATA_W'(int'($urandom_range(16383)) - 8192);
        return DATA_W'($urandom());
    endfunction

    // Values on and next to the sigmoid and tanh segment boundaries.
    function automatic logic signed [DATA_W-1:0] pick_probe();
        int v;
        case ($urandom_range(15))
            0:       v = 0;
            1:       v = 1;
            2:       v = 2047;
            3:       v = 2048;
            4:       v = 4095;
            5:       v = 4096;
            6:       v = 4863;
            7:       v = 4864;
            8:       v = 9727;
            9:       v = 9728;
            10:      v = 10239;
            11:      v = 10240;
            12:      v = 20479;
            13:      v = 20480;
            14:      v = 32767;
            default: v = int'($urandom_range(32767));
        endcase
        return DATA_W'($urandom_range(1) ? -v : v);
    endfunction

    task automatic push_item(input item_t it);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.bias_value, it.weight_value, it.in_value};
        s_tuser  <= it.first_element;
        s_tlast  <= it.last_element;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Writes the mode with the block idle, then reads it back for the checker.
    task automatic write_act_mode(input act_mode_t mode);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ACT_MODE_ADDR;
        pwdata  <= ($urandom_range(1) ? ($urandom() & 32'hffff_fff8) : 32'h0)
                   | APB_DATA_W'(mode);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drives the accumulator to one limit, then back by a known amount, so the result only
    // comes out right if the accumulator clipped at the limit.
    task automatic overflow_run(input logic signed [DATA_W-1:0] x_up,
                                input logic signed [DATA_W-1:0] w_up,
                                input logic signed [DATA_W-1:0] x_down,
                                input logic signed [DATA_W-1:0] w_down,
                                input logic signed [DATA_W-1:0] bias);
        for (int i = 0; i < OVERFLOW_UP; i++)
            push_item(make_item(x_up, w_up, bias, i == 0, 1'b0));
        for (int i = 0; i < OVERFLOW_DOWN; i++)
            push_item(make_item(x_down, w_down, bias, 1'b0, 1'b0));
        push_item(make_item(16'sd0, 16'sd0, bias, 1'b0, 1'b1));
    endtask

    task automatic send_dot_product();
        int unsigned r;
        int          len;
        bit          skip_first;
        r = $urandom_range(99);
        if (r < 15) begin
            push_item(make_item(pick_probe(), 16'sd4096, 16'sd0, 1'b1, 1'b1));
        end else if (r < 23) begin
            push_item(make_item(pick_operand(), pick_operand(), pick_operand(),
                                1'($urandom_range(1)), 1'($urandom_range(1))));
        end else begin
            len = ($urandom_range(3) == 0) ? int'($urandom_range(12, 5))
                                           : int'($urandom_range(4, 1));
            // Now and then a dot product starts without clearing the accumulator.
            skip_first = ($urandom_range(9) == 0);
            for (int i = 0; i < len; i++)
                push_item(make_item(pick_operand(), pick_operand(), pick_operand(),
                                    i == 0 && !skip_first, i == len - 1));
        end
    endtask

    initial begin : stimulus
        int unsigned phase_end;
        act_mode_t   mode;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        // Directed part, still in the reset mode (linear).
        push_item(make_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1));
        push_item(make_item(16'sh8000, 16'sh8000, 16'sh0000, 1'b1, 1'b1));
        push_item(make_item(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 1'b1));
        push_item(make_item(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        // Exactly half an output LSB rounds up; just below half rounds down.
        push_item(make_item(16'sd1, 16'sd2048, 16'sd0, 1'b1, 1'b1));
        push_item(make_item(-16'sd1, 16'sd2048, 16'sd0, 1'b1, 1'b1));
        push_item(make_item(-16'sd1, 16'sd2049, 16'sd0, 1'b1, 1'b1));
        push_item(make_item(16'sd4096, 16'sd4096, 16'sh7fff, 1'b1, 1'b0));
        push_item(make_item(16'sd8192, -16'sd2048, 16'sh8000, 1'b0, 1'b0));
        push_item(make_item(-16'sd4096, 16'sd4096, 16'sd4096, 1'b0, 1'b1));
        // A dot product with no first flag builds on the previous sum.
        push_item(make_item(16'sd4096, 16'sd4096, 16'sd0, 1'b0, 1'b0));
        push_item(make_item(16'sd4096, 16'sd4096, -16'sd4096, 1'b0, 1'b1));
        push_item(make_item(16'sd12288, 16'sd4096, -16'sd4096, 1'b1, 1'b1));
        for (int m = int'(MODE_RELU); m <= int'(MODE_TOP_CODE); m++) begin
            write_act_mode(act_mode_t'(m));
            push_item(make_item(-16'sd6144, 16'sd4096, 16'sd0, 1'b1, 1'b1));
            push_item(make_item(16'sd12288, 16'sd4096, 16'sd0, 1'b1, 1'b1));
        end

        write_act_mode(MODE_LINEAR);
        overflow_run(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = (p <= int'(MODE_TOP_CODE)) ? act_mode_t'(p)
                                              : act_mode_t'($urandom_range(7));
            write_act_mode(mode);
            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 75; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 75; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                // Occasionally hold off until every result has come back.
                if ($urandom_range(49) == 0)
                    wait_results_drained();
                send_dot_product();
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run covered %0d input transactions and %0d results across all eight mode codes,",
                 items_sent, results_seen);
        $display("with accumulator clipping at the upper limit and four handshake idling patterns.");
        if (fail_count == 0)
            $display("** dense_neuron_mac_activation_top: PASSED **");
        else
            $display("** dense_neuron_mac_activation_top: FAILED **");
        $finish;
    end

endmodule
